### rtl/sgkp_pkg.sv
`timescale 1ns / 1ps

// Shared constants and types for the separable grid kernel projection block.
// The grid length and the samples per cell are powers of two.
package sgkp_pkg;

  // Geometry and number formats.
  localparam int GRID_LEN         = 32;
  localparam int SUPPORT          = 4;
  localparam int SAMPLES_PER_CELL = 64;
  localparam int FRAC_BITS        = 16;

  localparam int CELL_W   = $clog2(GRID_LEN);
  localparam int GRID_VOL = GRID_LEN * GRID_LEN * GRID_LEN;
  localparam int GRID_AW  = 3 * CELL_W;
  localparam int KERN_LEN = SUPPORT * SAMPLES_PER_CELL;
  localparam int KERN_AW  = $clog2(KERN_LEN);
  localparam int SUP_W    = $clog2(SUPPORT);
  localparam int PHASE_W  = $clog2(SAMPLES_PER_CELL);
  localparam int PH_W     = FRAC_BITS + PHASE_W + 1;

  // Field widths.
  localparam int TYPE_W  = 2;
  localparam int IDX_W   = 15;
  localparam int VAL_W   = 32;
  localparam int COORD_W = 21;
  localparam int INT_W   = COORD_W - FRAC_BITS;
  localparam int SUM_W   = 48;

  // Datapath widths: full product, product after rescale, accumulator.
  localparam int PROD_W = 2 * VAL_W;
  localparam int SHR_W  = PROD_W - FRAC_BITS;
  localparam int ACC_W  = SHR_W + $clog2(SUPPORT * SUPPORT * SUPPORT);

  // Stream packing.
  localparam int S_DATA_W = 112;
  localparam int S_USER_W = TYPE_W;
  localparam int M_DATA_W = SUM_W;
  localparam int M_USER_W = 1;
  localparam int IDX_LSB  = 0;
  localparam int VAL_LSB  = IDX_LSB + IDX_W;
  localparam int CX_LSB   = VAL_LSB + VAL_W;
  localparam int CY_LSB   = CX_LSB + COORD_W;
  localparam int CZ_LSB   = CY_LSB + COORD_W;

  // Axis codes used while the kernel samples are preloaded.
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef enum logic [TYPE_W-1:0] {
    REQ_GRID_WR = 2'd0,
    REQ_KERN_WR = 2'd1,
    REQ_QUERY   = 2'd2
  } req_type_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_LOAD_WAIT,
    ST_PAIR,
    ST_PAIR_SAT,
    ST_WEIGHT,
    ST_GRID,
    ST_FLUSH,
    ST_DONE
  } seq_state_e;

  // Commands to the shared multiply-accumulate unit.
  typedef struct packed {
    logic mul_en;
    logic acc_clr;
    logic acc_add;
  } mac_ctrl_t;

  // Commands to the memory bank.
  typedef struct packed {
    logic grid_we;
    logic grid_re;
    logic kern_we;
    logic kern_re;
  } mem_ctrl_t;

endpackage

### rtl/sgkp_mem_bank.sv
`timescale 1ns / 1ps

// Density grid and kernel table, each with one write and one registered read port.
module sgkp_mem_bank (
  input  logic                                 clk_i,
  input  sgkp_pkg::mem_ctrl_t                  ctrl_i,
  input  logic        [sgkp_pkg::GRID_AW-1:0]  grid_waddr_i,
  input  logic        [sgkp_pkg::GRID_AW-1:0]  grid_raddr_i,
  input  logic        [sgkp_pkg::KERN_AW-1:0]  kern_waddr_i,
  input  logic        [sgkp_pkg::KERN_AW-1:0]  kern_raddr_i,
  input  logic signed [sgkp_pkg::VAL_W-1:0]    wdata_i,
  output logic signed [sgkp_pkg::VAL_W-1:0]    grid_rdata_o,
  output logic signed [sgkp_pkg::VAL_W-1:0]    kern_rdata_o
);

  logic signed [sgkp_pkg::VAL_W-1:0] grid_mem [sgkp_pkg::GRID_VOL];
  logic signed [sgkp_pkg::VAL_W-1:0] kern_mem [sgkp_pkg::KERN_LEN];

  // Grid memory.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.grid_we) begin
      grid_mem[grid_waddr_i] <= wdata_i;
    end
    if (ctrl_i.grid_re) begin
      grid_rdata_o <= grid_mem[grid_raddr_i];
    end
  end

  // Kernel table memory.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.kern_we) begin
      kern_mem[kern_waddr_i] <= wdata_i;
    end
    if (ctrl_i.kern_re) begin
      kern_rdata_o <= kern_mem[kern_raddr_i];
    end
  end

endmodule

### rtl/sgkp_mac.sv
`timescale 1ns / 1ps

// Shared signed multiplier with a registered product, a rescale and clip to
// 32 bits for weights, and an exact accumulator clipped to 48 bits at the end.
module sgkp_mac (
  input  logic                                clk_i,
  input  sgkp_pkg::mac_ctrl_t                 ctrl_i,
  input  logic signed [sgkp_pkg::VAL_W-1:0]   op_a_i,
  input  logic signed [sgkp_pkg::VAL_W-1:0]   op_b_i,
  output logic signed [sgkp_pkg::VAL_W-1:0]   weight_o,
  output logic signed [sgkp_pkg::SUM_W-1:0]   sum_o,
  output logic                                sat_o
);

  localparam int SHR_W = sgkp_pkg::SHR_W;
  localparam int VAL_W = sgkp_pkg::VAL_W;
  localparam int ACC_W = sgkp_pkg::ACC_W;
  localparam int SUM_W = sgkp_pkg::SUM_W;

  logic signed [sgkp_pkg::PROD_W-1:0] prod_q, prod_d;
  logic signed [ACC_W-1:0]            acc_q, acc_d;
  logic signed [SHR_W-1:0]            shr;
  logic        [SHR_W-VAL_W:0]        shr_hi;
  logic        [ACC_W-SUM_W:0]        acc_hi;

  // One multiplication per cycle into the product register, while mul_en is set.
  assign prod_d = sgkp_pkg::PROD_W'(op_a_i) * sgkp_pkg::PROD_W'(op_b_i);

  // Rescale rounds toward minus infinity.
  assign shr    = SHR_W'(prod_q >>> sgkp_pkg::FRAC_BITS);
  assign shr_hi = shr[SHR_W-1:VAL_W-1];

  // Weight clipped silently to signed 32 bits.
  always_comb begin
    if ((&shr_hi) || !(|shr_hi)) begin
      weight_o = shr[VAL_W-1:0];
    end else if (shr[SHR_W-1]) begin
      weight_o = {1'b1, {(VAL_W-1){1'b0}}};
    end else begin
      weight_o = {1'b0, {(VAL_W-1){1'b1}}};
    end
  end

  // Accumulator update.
  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.acc_clr) begin
      acc_d = '0;
    end else if (ctrl_i.acc_add) begin
      acc_d = acc_q + ACC_W'(shr);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= prod_d;
    end
    acc_q <= acc_d;
  end

  // Final clip to signed 48 bits.
  assign acc_hi = acc_q[ACC_W-1:SUM_W-1];

  always_comb begin
    sat_o = 1'b0;
    sum_o = acc_q[SUM_W-1:0];
    if (!((&acc_hi) || !(|acc_hi))) begin
      sat_o = 1'b1;
      sum_o = acc_q[ACC_W-1] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end
  end

endmodule

### rtl/separable_grid_kernel_projection_top.sv
`timescale 1ns / 1ps

// Separable kernel projection on a periodic cubic grid. Beats of type grid write
// and kernel write store a signed Q15.16 value (a kernel write only at an index
// below KERN_LEN) and answer a zero sum in the next cycle; a query beat splits
// each Q5.16 coordinate into a cell and a kernel phase and returns the
// kernel-weighted sum of the SUPPORT-cubed cells behind it, signed Q31.16
// clipped to 48 bits, with tuser set when it was clipped. The kernel samples
// of a query are first fetched one per cycle from the kernel table port, and
// then a single 32x32 multiplier forms two products for every neighbor
// (weight times kz, grid value times weight) plus one kx*ky pair product per
// row. The input is taken again once the result has been handed to the output
// register and that register is free or being read. Grid and kernel entries
// must be written before a query reads them.
module separable_grid_kernel_projection_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_tvalid_i,
  output logic                            s_tready_o,
  // From bit 0: entry_index[14:0], entry_value[31:0], coord_x[20:0],
  // coord_y[20:0], coord_z[20:0], two zero bits.
  input  logic [sgkp_pkg::S_DATA_W-1:0]   s_tdata_i,
  // From bit 0: req_type[1:0].
  input  logic [sgkp_pkg::S_USER_W-1:0]   s_tuser_i,
  output logic                            m_tvalid_o,
  input  logic                            m_tready_i,
  // From bit 0: projected_sum[47:0].
  output logic [sgkp_pkg::M_DATA_W-1:0]   m_tdata_o,
  // From bit 0: saturated.
  output logic [sgkp_pkg::M_USER_W-1:0]   m_tuser_o
);

  localparam int SUPPORT = sgkp_pkg::SUPPORT;
  localparam int SUP_W   = sgkp_pkg::SUP_W;
  localparam int CELL_W  = sgkp_pkg::CELL_W;
  localparam int PHASE_W = sgkp_pkg::PHASE_W;
  localparam int VAL_W   = sgkp_pkg::VAL_W;
  localparam int KERN_AW = sgkp_pkg::KERN_AW;
  localparam int FRAC_W  = sgkp_pkg::FRAC_BITS;

  // Cell index of a coordinate: integer part modulo the grid length.
  function automatic logic [CELL_W-1:0] cell_of(input logic [sgkp_pkg::COORD_W-1:0] c);
    logic [sgkp_pkg::INT_W-1:0] ip;
    ip = c[sgkp_pkg::COORD_W-1:FRAC_W];
    return CELL_W'(32'(ip) % sgkp_pkg::GRID_LEN);
  endfunction

  // Kernel phase of a coordinate: fraction times samples per cell, rounded down.
  function automatic logic [PHASE_W-1:0] phase_of(input logic [sgkp_pkg::COORD_W-1:0] c);
    logic [sgkp_pkg::PH_W-1:0] prod;
    prod = sgkp_pkg::PH_W'(c[FRAC_W-1:0]) * sgkp_pkg::PH_W'(sgkp_pkg::SAMPLES_PER_CELL);
    return PHASE_W'(prod >> FRAC_W);
  endfunction

  // Input beat fields.
  sgkp_pkg::req_type_e                s_type;
  logic        [sgkp_pkg::IDX_W-1:0]  s_idx;
  logic signed [VAL_W-1:0]            s_val;
  logic [sgkp_pkg::COORD_W-1:0]       s_cx, s_cy, s_cz;

  assign s_type = sgkp_pkg::req_type_e'(s_tuser_i[sgkp_pkg::TYPE_W-1:0]);
  assign s_idx  = s_tdata_i[sgkp_pkg::IDX_LSB +: sgkp_pkg::IDX_W];
  assign s_val  = s_tdata_i[sgkp_pkg::VAL_LSB +: VAL_W];
  assign s_cx   = s_tdata_i[sgkp_pkg::CX_LSB +: sgkp_pkg::COORD_W];
  assign s_cy   = s_tdata_i[sgkp_pkg::CY_LSB +: sgkp_pkg::COORD_W];
  assign s_cz   = s_tdata_i[sgkp_pkg::CZ_LSB +: sgkp_pkg::COORD_W];

  // Sequencer state and loop counters.
  sgkp_pkg::seq_state_e state_q, state_d;
  logic [1:0]           ld_axis_q, ld_axis_d;
  logic [SUP_W-1:0]     ld_slot_q, ld_slot_d;
  logic [SUP_W-1:0]     i_q, i_d, j_q, j_d, k_q, k_d;
  logic                 pend_q, pend_d;
  logic                 rd_vld_q;
  logic [1:0]           rd_axis_q;
  logic [SUP_W-1:0]     rd_slot_q;

  // Query operands.
  logic [CELL_W-1:0]       cx_q, cy_q, cz_q;
  logic [PHASE_W-1:0]      px_q, py_q, pz_q;
  logic signed [VAL_W-1:0] kx_q [SUPPORT];
  logic signed [VAL_W-1:0] ky_q [SUPPORT];
  logic signed [VAL_W-1:0] kz_q [SUPPORT];
  logic signed [VAL_W-1:0] wxy_q;

  // Output register.
  logic                                m_valid_q;
  logic signed [sgkp_pkg::SUM_W-1:0]   m_sum_q;
  logic                                m_sat_q;

  // Control from the sequencer.
  logic                    s_ready;
  logic                    query_start;
  logic                    wxy_load;
  logic                    out_load;
  logic                    out_zero;
  sgkp_pkg::mac_ctrl_t     mac_ctrl;
  sgkp_pkg::mem_ctrl_t     mem_ctrl;
  logic signed [VAL_W-1:0] op_a, op_b;

  // Datapath signals.
  logic signed [VAL_W-1:0]           grid_rd, kern_rd, weight;
  logic signed [sgkp_pkg::SUM_W-1:0] mac_sum;
  logic                              mac_sat;
  logic [PHASE_W-1:0]                ld_phase;
  logic [KERN_AW-1:0]                kern_raddr;
  logic [sgkp_pkg::GRID_AW-1:0]      grid_raddr;
  logic [CELL_W-1:0]                 gx, gy, gz;
  logic                              grid_idx_ok, kern_idx_ok;

  assign grid_idx_ok = 32'(s_idx) < 32'(sgkp_pkg::GRID_VOL);
  assign kern_idx_ok = 32'(s_idx) < 32'(sgkp_pkg::KERN_LEN);

  // Kernel preload address: phase plus slot times samples per cell.
  always_comb begin
    case (ld_axis_q)
      sgkp_pkg::AXIS_X: ld_phase = px_q;
      sgkp_pkg::AXIS_Y: ld_phase = py_q;
      default:          ld_phase = pz_q;
    endcase
  end

  assign kern_raddr = KERN_AW'(ld_phase)
                    + KERN_AW'(ld_slot_q) * KERN_AW'(sgkp_pkg::SAMPLES_PER_CELL);

  // Neighbor address, stepping backwards from the cell with wraparound.
  assign gx         = cx_q - CELL_W'(i_q);
  assign gy         = cy_q - CELL_W'(j_q);
  assign gz         = cz_q - CELL_W'(k_q);
  assign grid_raddr = {gx, gy, gz};

  // Sequencer: next state, counters and datapath commands.
  always_comb begin
    state_d     = state_q;
    ld_axis_d   = ld_axis_q;
    ld_slot_d   = ld_slot_q;
    i_d         = i_q;
    j_d         = j_q;
    k_d         = k_q;
    pend_d      = pend_q;
    s_ready     = 1'b0;
    query_start = 1'b0;
    wxy_load    = 1'b0;
    out_load    = 1'b0;
    out_zero    = 1'b0;
    mac_ctrl    = '0;
    mem_ctrl    = '0;
    op_a        = kx_q[i_q];
    op_b        = ky_q[j_q];

    case (state_q)
      sgkp_pkg::ST_IDLE: begin
        s_ready = !m_valid_q || m_tready_i;
        if (s_tvalid_i && s_ready) begin
          case (s_type)
            sgkp_pkg::REQ_GRID_WR: begin
              mem_ctrl.grid_we = grid_idx_ok;
              out_load         = 1'b1;
              out_zero         = 1'b1;
            end
            sgkp_pkg::REQ_KERN_WR: begin
              mem_ctrl.kern_we = kern_idx_ok;
              out_load         = 1'b1;
              out_zero         = 1'b1;
            end
            sgkp_pkg::REQ_QUERY: begin
              query_start      = 1'b1;
              mac_ctrl.acc_clr = 1'b1;
              pend_d           = 1'b0;
              ld_axis_d        = sgkp_pkg::AXIS_X;
              ld_slot_d        = '0;
              i_d              = '0;
              j_d              = '0;
              k_d              = '0;
              state_d          = sgkp_pkg::ST_LOAD;
            end
            default: begin
              out_load = 1'b1;
              out_zero = 1'b1;
            end
          endcase
        end
      end

      // Fetch SUPPORT samples for each axis, one per cycle.
      sgkp_pkg::ST_LOAD: begin
        mem_ctrl.kern_re = 1'b1;
        if (ld_slot_q == SUP_W'(SUPPORT - 1)) begin
          ld_slot_d = '0;
          if (ld_axis_q == sgkp_pkg::AXIS_Z) begin
            state_d = sgkp_pkg::ST_LOAD_WAIT;
          end else begin
            ld_axis_d = ld_axis_q + 2'd1;
          end
        end else begin
          ld_slot_d = ld_slot_q + SUP_W'(1);
        end
      end

      sgkp_pkg::ST_LOAD_WAIT: begin
        state_d = sgkp_pkg::ST_PAIR;
      end

      // kx * ky for a new row; retire the previous grid product.
      sgkp_pkg::ST_PAIR: begin
        mac_ctrl.mul_en  = 1'b1;
        mac_ctrl.acc_add = pend_q;
        pend_d           = 1'b0;
        state_d          = sgkp_pkg::ST_PAIR_SAT;
      end

      sgkp_pkg::ST_PAIR_SAT: begin
        wxy_load = 1'b1;
        state_d  = sgkp_pkg::ST_WEIGHT;
      end

      // wxy * kz while the grid cell is read.
      sgkp_pkg::ST_WEIGHT: begin
        op_a             = wxy_q;
        op_b             = kz_q[k_q];
        mac_ctrl.mul_en  = 1'b1;
        mac_ctrl.acc_add = pend_q;
        mem_ctrl.grid_re = 1'b1;
        pend_d           = 1'b0;
        state_d          = sgkp_pkg::ST_GRID;
      end

      // Grid value times the clipped weight, then step the loops.
      sgkp_pkg::ST_GRID: begin
        op_a            = grid_rd;
        op_b            = weight;
        mac_ctrl.mul_en = 1'b1;
        pend_d          = 1'b1;
        if (k_q == SUP_W'(SUPPORT - 1)) begin
          k_d = '0;
          if (j_q == SUP_W'(SUPPORT - 1)) begin
            j_d = '0;
            if (i_q == SUP_W'(SUPPORT - 1)) begin
              i_d     = '0;
              state_d = sgkp_pkg::ST_FLUSH;
            end else begin
              i_d     = i_q + SUP_W'(1);
              state_d = sgkp_pkg::ST_PAIR;
            end
          end else begin
            j_d     = j_q + SUP_W'(1);
            state_d = sgkp_pkg::ST_PAIR;
          end
        end else begin
          k_d     = k_q + SUP_W'(1);
          state_d = sgkp_pkg::ST_WEIGHT;
        end
      end

      sgkp_pkg::ST_FLUSH: begin
        mac_ctrl.acc_add = pend_q;
        pend_d           = 1'b0;
        state_d          = sgkp_pkg::ST_DONE;
      end

      sgkp_pkg::ST_DONE: begin
        if (!m_valid_q || m_tready_i) begin
          out_load = 1'b1;
          state_d  = sgkp_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = sgkp_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= sgkp_pkg::ST_IDLE;
      ld_axis_q <= sgkp_pkg::AXIS_X;
      ld_slot_q <= '0;
      i_q       <= '0;
      j_q       <= '0;
      k_q       <= '0;
      pend_q    <= 1'b0;
      rd_vld_q  <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      ld_axis_q <= ld_axis_d;
      ld_slot_q <= ld_slot_d;
      i_q       <= i_d;
      j_q       <= j_d;
      k_q       <= k_d;
      pend_q    <= pend_d;
      rd_vld_q  <= (state_q == sgkp_pkg::ST_LOAD);
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Query operands and kernel sample capture.
  always_ff @(posedge clk_i) begin
    if (query_start) begin
      cx_q <= cell_of(s_cx);
      cy_q <= cell_of(s_cy);
      cz_q <= cell_of(s_cz);
      px_q <= phase_of(s_cx);
      py_q <= phase_of(s_cy);
      pz_q <= phase_of(s_cz);
    end
    rd_axis_q <= ld_axis_q;
    rd_slot_q <= ld_slot_q;
    if (rd_vld_q) begin
      case (rd_axis_q)
        sgkp_pkg::AXIS_X: kx_q[rd_slot_q] <= kern_rd;
        sgkp_pkg::AXIS_Y: ky_q[rd_slot_q] <= kern_rd;
        default:          kz_q[rd_slot_q] <= kern_rd;
      endcase
    end
    if (wxy_load) begin
      wxy_q <= weight;
    end
  end

  // Output payload.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_sum_q <= out_zero ? '0 : mac_sum;
      m_sat_q <= out_zero ? 1'b0 : mac_sat;
    end
  end

  sgkp_mem_bank u_mem_bank (
    .clk_i        (clk_i),
    .ctrl_i       (mem_ctrl),
    .grid_waddr_i (sgkp_pkg::GRID_AW'(s_idx)),
    .grid_raddr_i (grid_raddr),
    .kern_waddr_i (KERN_AW'(s_idx)),
    .kern_raddr_i (kern_raddr),
    .wdata_i      (s_val),
    .grid_rdata_o (grid_rd),
    .kern_rdata_o (kern_rd)
  );

  sgkp_mac u_mac (
    .clk_i    (clk_i),
    .ctrl_i   (mac_ctrl),
    .op_a_i   (op_a),
    .op_b_i   (op_b),
    .weight_o (weight),
    .sum_o    (mac_sum),
    .sat_o    (mac_sat)
  );

  assign s_tready_o = s_ready;
  assign m_tvalid_o = m_valid_q;
  assign m_tdata_o  = m_sum_q;
  assign m_tuser_o  = m_sat_q;

endmodule
